>>> src/range_clamp_kth_smallest_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the range clamp k-th smallest block
// Property wrappers used by the rck_engine RTL module.
// ----------------------------------------------------------------------------
`ifndef RANGE_CLAMP_KTH_SMALLEST_MACROS_SVH
`define RANGE_CLAMP_KTH_SMALLEST_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RCK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define RCK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rck_pkg.sv
// ----------------------------------------------------------------------------
// rck_pkg
// Shared widths, opcodes and types for the range clamp k-th smallest block.
// ----------------------------------------------------------------------------
package rck_pkg;

  localparam int unsigned FieldW          = 11;
  localparam int unsigned DefMaxEntries   = 1024;
  localparam int unsigned ValueBins       = 2048;
  localparam int unsigned BinW            = 11;
  localparam logic [FieldW-1:0] SizeReset = 11'd1024;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CLAMP = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Request handed from the top level to the engine.
  typedef struct packed {
    op_t              op;
    logic [FieldW-1:0] lo;
    logic [FieldW-1:0] hi;
    logic [FieldW-1:0] amount;
  } rck_req_t;

endpackage

>>> src/rck_hist.sv
// ----------------------------------------------------------------------------
// rck_hist
// Histogram memory for the query: clear, count and prefix-scan passes.
// ----------------------------------------------------------------------------
module rck_hist import rck_pkg::*; #(
  parameter int unsigned CntW = 11
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [BinW-1:0] wr_addr,
  input  logic [CntW-1:0] wr_data,
  input  logic [BinW-1:0] rd_addr,
  output logic [CntW-1:0] rd_data
);

  logic [CntW-1:0] mem [ValueBins];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/rck_store.sv
// ----------------------------------------------------------------------------
// rck_store
// Value memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rck_store import rck_pkg::*; #(
  parameter int unsigned MaxEntries = DefMaxEntries,
  parameter int unsigned AddrW      = $clog2(MaxEntries)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AddrW-1:0]  wr_addr,
  input  logic [FieldW-1:0] wr_data,
  input  logic [AddrW-1:0]  rd_addr,
  output logic [FieldW-1:0] rd_data
);

  logic [FieldW-1:0] mem [MaxEntries];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/rck_engine.sv
// ----------------------------------------------------------------------------
// rck_engine
// Sequencer: runs writes, clamp sweeps and histogram-based queries.
// ----------------------------------------------------------------------------
`include "range_clamp_kth_smallest_macros.svh"
module rck_engine import rck_pkg::*; #(
  parameter int unsigned MaxEntries = DefMaxEntries,
  parameter int unsigned AddrW      = $clog2(MaxEntries),
  parameter int unsigned CntW       = AddrW + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  rck_req_t          req,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [FieldW-1:0] res_value,
  output logic              res_error
);

  typedef enum logic [2:0] {
    S_IDLE, S_CLAMP, S_HCLR, S_HCNT, S_SCAN, S_DONE
  } state_t;

  // Index counters are wide enough to reach the top entry plus one.
  localparam int unsigned IdxW = (AddrW + 1 > FieldW) ? AddrW + 1 : FieldW;

  state_t            state_r;
  rck_req_t          req_r;
  logic [IdxW-1:0]   idx_r;
  logic              rd_vld_r;
  logic [IdxW-1:0]   rd_idx_r;
  logic [BinW:0]     bin_r;
  logic [CntW-1:0]   acc_r;
  logic              res_valid_r;
  logic [FieldW-1:0] res_value_r;
  logic              res_error_r;

  logic              st_we;
  logic [AddrW-1:0]  st_wa;
  logic [FieldW-1:0] st_wd;
  logic [AddrW-1:0]  st_ra;
  logic [FieldW-1:0] st_rd;

  logic              h_we;
  logic [BinW-1:0]   h_wa;
  logic [CntW-1:0]   h_wd;
  logic [BinW-1:0]   h_ra;
  logic [CntW-1:0]   h_rd;

  logic              cnt_vld_r;
  logic [BinW-1:0]   cnt_bin_r;
  logic [CntW-1:0]   cnt_base;
  logic [CntW-1:0]   cnt_last_r;
  logic              issue;
  logic [CntW-1:0]   acc_sum;
  logic [BinW-1:0]   h_ra_q;
  logic              bin_vld_r;
  logic              scan_vld_r;

  rck_store #(.MaxEntries(MaxEntries), .AddrW(AddrW)) u_store (
    .clk, .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
    .rd_addr(st_ra), .rd_data(st_rd)
  );

  rck_hist #(.CntW(CntW)) u_hist (
    .clk, .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd),
    .rd_addr(h_ra), .rd_data(h_rd)
  );

  assign req_ready = (state_r == S_IDLE) && !res_valid_r;
  assign res_valid = res_valid_r;
  assign res_value = res_value_r;
  assign res_error = res_error_r;

  // Entries are stored at index-1.
  assign issue = (idx_r <= IdxW'(req_r.hi));
  assign st_ra = AddrW'(idx_r - IdxW'(1));

  // Histogram count pipeline: store read -> bin read -> increment write.
  assign h_ra     = (state_r == S_SCAN) ? bin_r[BinW-1:0] : st_rd;
  assign cnt_base = (cnt_vld_r && cnt_bin_r == h_ra_q) ? cnt_last_r : h_rd;
  assign acc_sum  = acc_r + h_rd;

  always_comb begin
    st_we = 1'b0;
    st_wa = AddrW'(rd_idx_r - IdxW'(1));
    st_wd = req_r.amount;
    h_we  = 1'b0;
    h_wa  = h_ra_q;
    h_wd  = cnt_base + CntW'(1);
    if (state_r == S_IDLE && req_valid && req_ready && req.op == OP_WRITE) begin
      st_we = 1'b1;
      st_wa = AddrW'(req.lo - FieldW'(1));
      st_wd = req.amount;
    end else if (state_r == S_CLAMP && rd_vld_r && st_rd > req_r.amount) begin
      st_we = 1'b1;
    end else if (state_r == S_HCLR) begin
      h_we = 1'b1;
      h_wa = bin_r[BinW-1:0];
      h_wd = '0;
    end else if (state_r == S_HCNT && bin_vld_r) begin
      h_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      bin_vld_r   <= 1'b0;
      cnt_vld_r   <= 1'b0;
      scan_vld_r  <= 1'b0;
    end else begin
      if (res_valid_r && res_ready) begin
        res_valid_r <= 1'b0;
      end
      rd_idx_r   <= idx_r;
      h_ra_q     <= h_ra;
      cnt_vld_r  <= (state_r == S_HCNT) && bin_vld_r;
      cnt_bin_r  <= h_ra_q;
      cnt_last_r <= h_wd;
      unique case (state_r)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            req_r <= req;
            idx_r <= IdxW'(req.lo);
            bin_r <= '0;
            acc_r <= '0;
            unique case (req.op)
              OP_CLAMP: state_r <= S_CLAMP;
              OP_QUERY: state_r <= S_HCLR;
              default:  state_r <= S_IDLE;
            endcase
            rd_vld_r <= 1'b0;
          end
        end
        S_CLAMP: begin
          rd_vld_r <= issue;
          if (issue) begin
            idx_r <= idx_r + IdxW'(1);
          end else if (!rd_vld_r) begin
            state_r <= S_IDLE;
          end
        end
        S_HCLR: begin
          bin_r <= bin_r + 1'b1;
          if (bin_r[BinW-1:0] == '1) begin
            state_r <= S_HCNT;
            bin_r   <= '0;
          end
        end
        S_HCNT: begin
          rd_vld_r  <= issue;
          bin_vld_r <= rd_vld_r;
          if (issue) begin
            idx_r <= idx_r + IdxW'(1);
          end else if (!rd_vld_r && !bin_vld_r) begin
            state_r    <= S_SCAN;
            scan_vld_r <= 1'b0;
          end
        end
        S_SCAN: begin
          scan_vld_r <= 1'b1;
          bin_r      <= bin_r + 1'b1;
          if (scan_vld_r) begin
            acc_r <= acc_sum;
            if ({1'b0, acc_sum} >= (CntW+1)'(req_r.amount)) begin
              res_value_r <= FieldW'(bin_r - 1'b1);
              res_error_r <= 1'b0;
              res_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `RCK_ASSERT_IMP(a_busy_no_ready, clk, rst_n, state_r != S_IDLE, !req_ready,
    "ready while busy")
  `RCK_ASSERT_IMP(a_res_no_ready, clk, rst_n, res_valid_r, !req_ready,
    "ready while result pending")
  `RCK_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid_r && !res_ready,
    res_valid_r && $stable(res_value_r), "result dropped")

endmodule

>>> src/range_clamp_kth_smallest.sv
// ----------------------------------------------------------------------------
// range_clamp_kth_smallest
// Array of values with range clamp and range k-th smallest queries.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid/in_ready with in_op, in_first_index,
// in_last_index and in_amount. Writes and clamps give no result; a query
// gives one result on out_valid/out_ready (out_kth_value, out_error).
// A write goes to the value memory as it is accepted. A clamp sweeps the range,
// one store entry per cycle through the single value memory read port.
// A query clears every bin of the histogram memory, counts the range into it,
// then scans the bins in order until the running sum reaches the amount, using
// its one write and one read port. One request is in flight at a time.
// Reset (synchronous, rst_n low) sets size_in_use to 1024; the value memory
// holds undefined data until written. While out_valid waits on out_ready the
// block accepts no new request. size_in_use sits at address 0 of the cfg
// port and should be written only while idle.
// ----------------------------------------------------------------------------
module range_clamp_kth_smallest import rck_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = DefMaxEntries
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [FieldW-1:0] in_first_index,
  input  logic [FieldW-1:0] in_last_index,
  input  logic [FieldW-1:0] in_amount,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FieldW-1:0] out_kth_value,
  output logic              out_error,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int unsigned AddrW = $clog2(MAX_ENTRIES);
  localparam int unsigned SizeW = AddrW + 1;

  logic [FieldW-1:0] size_r;
  logic [SizeW+FieldW:0] size_eff;
  logic              e_valid, e_ready, e_err, e_rvalid;
  logic [FieldW-1:0] e_value;
  rck_req_t          req;
  logic              bad_q, bad_c, drop, err_pend_r;
  logic [FieldW:0]   len;
  logic [FieldW-1:0] lo_c, hi_c;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = 32'(size_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SizeReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr) begin
      size_r <= cfg_pwdata[FieldW-1:0];
    end
  end

  always_comb begin
    if (size_r == '0) size_eff = (SizeW+FieldW+1)'(1);
    else if ((SizeW+FieldW+1)'(size_r) > (SizeW+FieldW+1)'(MAX_ENTRIES))
      size_eff = (SizeW+FieldW+1)'(MAX_ENTRIES);
    else size_eff = (SizeW+FieldW+1)'(size_r);
  end

  assign len   = {1'b0, in_last_index} - {1'b0, in_first_index} + 1'b1;
  assign bad_q = in_first_index == '0 ||
                 (SizeW+FieldW+1)'(in_last_index) > size_eff ||
                 in_first_index > in_last_index || in_amount == '0 ||
                 {1'b0, in_amount} > len;
  assign lo_c  = (in_first_index == '0) ? FieldW'(1) : in_first_index;
  assign hi_c  = ((SizeW+FieldW+1)'(in_last_index) > size_eff) ?
                 FieldW'(size_eff) : in_last_index;
  assign bad_c = (SizeW+FieldW+1)'(in_amount) >= size_eff || lo_c > hi_c;

  always_comb begin
    drop = 1'b0;
    case (in_op)
      OP_WRITE: drop = in_first_index == '0 ||
                       (SizeW+FieldW+1)'(in_first_index) > size_eff;
      OP_CLAMP: drop = bad_c;
      OP_QUERY: drop = bad_q;
      default:  drop = 1'b1;
    endcase
  end

  assign req.op     = op_t'(in_op);
  assign req.lo     = (in_op == OP_CLAMP) ? lo_c : in_first_index;
  assign req.hi     = (in_op == OP_CLAMP) ? hi_c : in_last_index;
  assign req.amount = in_amount;

  assign in_ready = e_ready && !err_pend_r;
  assign e_valid  = in_valid && !err_pend_r && !drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_pend_r <= 1'b0;
    end else if (err_pend_r && out_ready) begin
      err_pend_r <= 1'b0;
    end else if (in_valid && in_ready && drop && in_op == OP_QUERY) begin
      err_pend_r <= 1'b1;
    end
  end

  rck_engine #(.MaxEntries(MAX_ENTRIES), .AddrW(AddrW)) u_engine (
    .clk, .rst_n, .req_valid(e_valid), .req_ready(e_ready), .req,
    .res_valid(e_rvalid), .res_ready(out_ready && !err_pend_r),
    .res_value(e_value), .res_error(e_err)
  );

  assign out_valid     = err_pend_r || e_rvalid;
  assign out_kth_value = err_pend_r ? '0 : e_value;
  assign out_error     = err_pend_r ? 1'b1 : e_err;

endmodule

>>> tb/tb_range_clamp_kth_smallest.sv
// ----------------------------------------------------------------------------
// tb_range_clamp_kth_smallest
// Checks range writes, clamps and k-th smallest queries against an in-bench
// model of the value array. A preload fills the entries in use, a short
// directed table covers error and boundary requests, then random traffic
// runs under three idle mixes and several array sizes, with one long output
// stall.
// ----------------------------------------------------------------------------
module tb_range_clamp_kth_smallest import rck_pkg::*;;

  localparam int unsigned Entries    = 1024;
  localparam int unsigned Preload    = 128;
  localparam int          HoldCycles = 15000;

  typedef struct {
    op_t              op;
    logic [FieldW-1:0] first;
    logic [FieldW-1:0] last;
    logic [FieldW-1:0] amount;
    bit               typed;
    logic [FieldW-1:0] kth;
    logic             err;
  } table_row_t;

  typedef struct {
    logic [FieldW-1:0] kth;
    logic             err;
  } kth_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_op;
  logic [FieldW-1:0] in_first_index;
  logic [FieldW-1:0] in_last_index;
  logic [FieldW-1:0] in_amount;
  logic              out_valid;
  logic              out_ready;
  logic [FieldW-1:0] out_kth_value;
  logic              out_error;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic              cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  logic [FieldW-1:0] model_store [1:Entries];
  logic [FieldW-1:0] model_size;
  kth_result_t       pending_kth [$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  bit hold_go;
  bit hold_used;
  int errors;
  int n_writes, n_clamps, n_queries, n_results;

  range_clamp_kth_smallest dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned eff_size();
    if (model_size < 1) return 1;
    if (model_size > Entries) return Entries;
    return model_size;
  endfunction

  // Updates the model for one accepted request; returns 1 when a result is due.
  function automatic bit model_request(op_t op, int unsigned f, int unsigned l,
                                       int unsigned a, output kth_result_t res);
    int unsigned sz;
    int unsigned lo;
    int unsigned hi;
    int unsigned acc;
    int unsigned hist [0:2047];
    sz = eff_size();
    res.kth = '0;
    res.err = 1'b1;
    case (op)
      OP_WRITE: begin
        if (f >= 1 && f <= sz) model_store[f] = FieldW'(a);
        return 0;
      end
      OP_CLAMP: begin
        lo = (f < 1) ? 1 : f;
        hi = (l > sz) ? sz : l;
        if (a < sz)
          for (int unsigned i = lo; i <= hi; i++)
            if (model_store[i] > a) model_store[i] = FieldW'(a);
        return 0;
      end
      OP_QUERY: begin
        if (f < 1 || l > sz || f > l || a == 0 || a > l - f + 1) return 1;
        foreach (hist[i]) hist[i] = 0;
        for (int unsigned i = f; i <= l; i++) hist[model_store[i]]++;
        acc = 0;
        for (int unsigned i = 0; i < 2048; i++) begin
          acc += hist[i];
          if (acc >= a) begin
            res.kth = FieldW'(i);
            res.err = 1'b0;
            return 1;
          end
        end
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic send_request(op_t op, logic [FieldW-1:0] f, logic [FieldW-1:0] l,
                              logic [FieldW-1:0] a, bit typed = 0,
                              logic [FieldW-1:0] tkth = '0, logic terr = 1'b0);
    kth_result_t res;
    int gap;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op = op;
    in_first_index = f;
    in_last_index = l;
    in_amount = a;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    case (op)
      OP_WRITE: n_writes++;
      OP_CLAMP: n_clamps++;
      OP_QUERY: n_queries++;
      default: ;
    endcase
    if (model_request(op, f, l, a, res)) begin
      if (typed) begin
        res.kth = tkth;
        res.err = terr;
      end
      pending_kth.push_back(res);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_kth.size() == 0);
    repeat (1200) @(posedge clk);
  endtask

  task automatic cfg_write_size(logic [FieldW-1:0] sz);
    drain();
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_paddr = 1'b0; cfg_pwdata = 32'(sz);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    model_size = sz;
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    @(negedge clk);
    cfg_psel = 1'b1;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[FieldW-1:0] !== sz) begin
      $display("%0t size readback: expected %0d actual %0d", $time, sz,
               cfg_prdata[FieldW-1:0]);
      errors++;
    end
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0;
  endtask

  task automatic random_request();
    int unsigned sz;
    int unsigned f;
    int unsigned l;
    int unsigned sel;
    sz = eff_size();
    sel = $urandom_range(99);
    if (sel < 10) begin
      send_request(op_t'($urandom_range(3)), FieldW'($urandom_range(2047)),
                   FieldW'($urandom_range(2047)), FieldW'($urandom_range(2047)));
      return;
    end
    f = $urandom_range(1, sz);
    l = ($urandom_range(3) == 0) ? $urandom_range(f, sz)
                                 : $urandom_range(f, (f + 40 > sz) ? sz : f + 40);
    if (sel < 40)
      send_request(OP_WRITE, FieldW'(f), FieldW'(l), FieldW'($urandom_range(0, sz)));
    else if (sel < 60)
      send_request(OP_CLAMP, FieldW'(f), FieldW'(l),
                   FieldW'($urandom_range(0, sz - 1)));
    else
      send_request(OP_QUERY, FieldW'(f), FieldW'(l),
                   FieldW'($urandom_range(1, l - f + 1)));
  endtask

  always @(negedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_kth.size() == 0) begin
        $display("%0t unexpected result: expected none actual kth %0d err %0b",
                 $time, out_kth_value, out_error);
        errors++;
      end else begin
        if (out_kth_value !== pending_kth[0].kth || out_error !== pending_kth[0].err) begin
          $display("%0t result mismatch: expected kth %0d err %0b actual kth %0d err %0b",
                   $time, pending_kth[0].kth, pending_kth[0].err, out_kth_value,
                   out_error);
          errors++;
        end
        void'(pending_kth.pop_front());
      end
    end
  end

  table_row_t directed [] = '{
    '{OP_QUERY, 11'd1,    11'd10,   11'd0,    1, 11'd0,    1'b1},
    '{OP_QUERY, 11'd0,    11'd10,   11'd1,    1, 11'd0,    1'b1},
    '{OP_QUERY, 11'd1,    11'd1025, 11'd1,    1, 11'd0,    1'b1},
    '{OP_QUERY, 11'd1,    11'd2047, 11'd1,    1, 11'd0,    1'b1},
    '{OP_QUERY, 11'd9,    11'd8,    11'd1,    1, 11'd0,    1'b1},
    '{OP_QUERY, 11'd5,    11'd8,    11'd5,    1, 11'd0,    1'b1},
    '{OP_QUERY, 11'd1,    11'd1,    11'd2047, 1, 11'd0,    1'b1},
    '{OP_WRITE, 11'd1,    11'd0,    11'd1024, 0, 11'd0,    1'b0},
    '{OP_QUERY, 11'd1,    11'd1,    11'd1,    1, 11'd1024, 1'b0},
    '{OP_WRITE, 11'd2,    11'd2047, 11'd0,    0, 11'd0,    1'b0},
    '{OP_QUERY, 11'd2,    11'd2,    11'd1,    1, 11'd0,    1'b0},
    '{OP_WRITE, 11'd3,    11'd0,    11'd2047, 0, 11'd0,    1'b0},
    '{OP_QUERY, 11'd3,    11'd3,    11'd1,    1, 11'd2047, 1'b0},
    '{OP_WRITE, 11'd0,    11'd0,    11'd7,    0, 11'd0,    1'b0},
    '{OP_WRITE, 11'd1025, 11'd0,    11'd7,    0, 11'd0,    1'b0},
    '{OP_WRITE, 11'd2047, 11'd0,    11'd7,    0, 11'd0,    1'b0},
    '{OP_CLAMP, 11'd1,    11'd3,    11'd128,  0, 11'd0,    1'b0},
    '{OP_CLAMP, 11'd1,    11'd3,    11'd2047, 0, 11'd0,    1'b0},
    '{OP_QUERY, 11'd1,    11'd1,    11'd1,    1, 11'd1024, 1'b0},
    '{OP_CLAMP, 11'd3,    11'd1,    11'd0,    0, 11'd0,    1'b0},
    '{OP_CLAMP, 11'd0,    11'd2047, 11'd100,  0, 11'd0,    1'b0},
    '{OP_NONE,  11'd1,    11'd5,    11'd1,    0, 11'd0,    1'b0},
    '{OP_CLAMP, 11'd0,    11'd1,    11'd0,    0, 11'd0,    1'b0},
    '{OP_QUERY, 11'd1,    11'd1,    11'd1,    1, 11'd0,    1'b0},
    '{OP_QUERY, 11'd1,    11'd128,  11'd128,  0, 11'd0,    1'b0}
  };

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_op = OP_WRITE;
    in_first_index = '0; in_last_index = '0; in_amount = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = 1'b0; cfg_pwdata = '0;
    hold_go = 1'b0; errors = 0;
    n_writes = 0; n_clamps = 0; n_queries = 0; n_results = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    model_size = SizeReset;
    for (int i = 1; i <= Entries; i++) model_store[i] = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Top entry is reachable only at the reset size.
    send_request(OP_WRITE, 11'd1024, '0, 11'd5);
    send_request(OP_QUERY, 11'd1024, 11'd1024, 11'd1, 1, 11'd5, 1'b0);

    cfg_write_size(FieldW'(Preload));
    for (int i = 1; i <= Preload; i++)
      send_request(OP_WRITE, FieldW'(i), '0, FieldW'($urandom_range(0, Preload)));

    send_idle_pct = 24; recv_idle_pct = 63;
    foreach (directed[i])
      send_request(directed[i].op, directed[i].first, directed[i].last,
                   directed[i].amount, directed[i].typed, directed[i].kth,
                   directed[i].err);
    repeat (50) random_request();

    send_idle_pct = 63; recv_idle_pct = 24;
    cfg_write_size(11'd0);
    repeat (15) random_request();
    cfg_write_size(11'd100);
    repeat (30) random_request();

    send_idle_pct = 0; recv_idle_pct = 0;
    cfg_write_size(FieldW'(Preload));
    hold_go = 1'b1;
    repeat (35) random_request();
    drain();

    $display("covered %0d writes, %0d clamps, %0d queries, %0d results checked",
             n_writes, n_clamps, n_queries, n_results);
    $display("sizes 1024, 128, 0 and 100 under three idle mixes and one long output stall");
    if (errors == 0 && pending_kth.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
